// ===== hdl/wps_pkg.sv =====
// shared types and constants for the wheel pair synchronizer
package wps_pkg;

  localparam int unsigned SpeedW  = 16;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned AccW    = 27;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QuotW   = 15;
  localparam int unsigned DivCntW = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMinSpeed = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPropGain = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIntGain  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMaxCorr  = 2'd3;

  // integral limit, 2.0 in Q.24
  localparam logic signed [29:0] IntegLimit = 30'sd33554432;

  typedef struct packed {
    logic load_in;
    logic check;
    logic clr_acc;
    logic div_load;
    logic div_sel;
    logic div_step;
    logic store_l;
    logic store_r;
    logic m1;
    logic m2;
    logic m3;
    logic m4;
    logic m5;
    logic m6;
    logic m7;
    logic out_load;
  } wps_cmd_t;

  typedef struct packed {
    logic act_ok;
    logic div_busy;
  } wps_status_t;

endpackage

// ===== hdl/wheel_pair_pi_synchronizer.sv =====
// top level of the wheel pair pi synchronizer
//
//  channel   direction  handshake          payload
//  s_axis    in         s_tvalid/s_tready  targets, actuals, step time; fresh in tuser
//  m_axis    out        m_tvalid/m_tready  commands, ratio error, correction; active in tuser
//  cfg       in         cfg_we_i           register index and write data
//
// an active item passes from accept to the earliest result handoff through the
// gate check, two 15-step shift-subtract divisions (load, steps and store each)
// in one shared divider, and seven multiply and shape steps
// an inactive item passes from accept through the gate check straight to result
// one item in flight; the result register holds until taken and a new item
// is accepted while it waits
// reset clears registers, integral and handshake state
module wheel_pair_pi_synchronizer import wps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // input item stream
  input  logic               s_tvalid,
  output logic               s_tready,
  // left_target, right_target, left_actual, right_actual, step_time
  input  logic [79:0]        s_tdata,
  // fresh
  input  logic               s_tuser,
  // result item stream
  output logic               m_tvalid,
  input  logic               m_tready,
  // left_cmd, right_cmd, ratio_error, correction, zero fill
  output logic [71:0]        m_tdata,
  // active
  output logic               m_tuser
);

  wps_cmd_t    cmd;
  wps_status_t status;

  // sequencer: accept, gate check, divisions, pi steps, result handoff
  wps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, integral state and result register
  wps_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_tdata),
    .in_fresh_i   (s_tuser),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_data_o   (m_tdata),
    .out_active_o (m_tuser)
  );

endmodule

// ===== hdl/wps_ctrl.sv =====
// sequencing state machine for the wheel pair synchronizer
module wps_ctrl import wps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  input  wps_status_t status_i,
  output wps_cmd_t    cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCheck = 4'd1;
  localparam logic [3:0] StDlLd  = 4'd2;
  localparam logic [3:0] StDlRun = 4'd3;
  localparam logic [3:0] StDrLd  = 4'd4;
  localparam logic [3:0] StDrRun = 4'd5;
  localparam logic [3:0] StM1    = 4'd6;
  localparam logic [3:0] StM2    = 4'd7;
  localparam logic [3:0] StM3    = 4'd8;
  localparam logic [3:0] StM4    = 4'd9;
  localparam logic [3:0] StM5    = 4'd10;
  localparam logic [3:0] StM6    = 4'd11;
  localparam logic [3:0] StM7    = 4'd12;
  localparam logic [3:0] StFin   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && m_tready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        cmd_o.check = 1'b1;
        if (status_i.act_ok) begin
          state_d = StDlLd;
        end else begin
          cmd_o.clr_acc = 1'b1;
          state_d = StFin;
        end
      end
      StDlLd: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = 1'b0;
        state_d = StDlRun;
      end
      StDlRun: begin
        if (status_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.store_l = 1'b1;
          state_d = StDrLd;
        end
      end
      StDrLd: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = 1'b1;
        state_d = StDrRun;
      end
      StDrRun: begin
        if (status_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.store_r = 1'b1;
          state_d = StM1;
        end
      end
      StM1: begin cmd_o.m1 = 1'b1; state_d = StM2; end
      StM2: begin cmd_o.m2 = 1'b1; state_d = StM3; end
      StM3: begin cmd_o.m3 = 1'b1; state_d = StM4; end
      StM4: begin cmd_o.m4 = 1'b1; state_d = StM5; end
      StM5: begin cmd_o.m5 = 1'b1; state_d = StM6; end
      StM6: begin cmd_o.m6 = 1'b1; state_d = StM7; end
      StM7: begin cmd_o.m7 = 1'b1; state_d = StFin; end
      StFin: begin
        if (!ovalid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign s_tready_o = (state_q == StIdle);
  assign m_tvalid_o = ovalid_q;

endmodule

// ===== hdl/wps_dp.sv =====
// datapath: config registers, shared divider, multiplies, integral, outputs
module wps_dp import wps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic [79:0]              in_data_i,
  input  logic                     in_fresh_i,
  input  wps_cmd_t                 cmd_i,
  output wps_status_t              status_o,
  output logic [71:0]              out_data_o,
  output logic                     out_active_o
);

  logic [14:0] min_speed_q;
  logic [15:0] prop_gain_q, integ_gain_q;
  logic [14:0] max_corr_q;

  logic signed [SpeedW-1:0] lt_q, rt_q, la_q, ra_q;
  logic [15:0] dt_q;
  logic        fresh_q, act_q;
  logic [15:0] peak_q;

  logic signed [AccW-1:0] acc_q;

  logic [27:0]        rem_q;
  logic [29:0]        dsh_q;
  logic [QuotW-1:0]   quo_q;
  logic [DivCntW-1:0] cnt_q;
  logic               ovf_q, neg_q;

  logic signed [SpeedW-1:0] lratio_q, rratio_q;
  logic signed [ErrW-1:0]   err_q;
  logic signed [33:0]       pdt_q, pterm_q;
  logic signed [43:0]       iterm_q;
  logic [46:0]              smag_q;
  logic                     sneg_q;
  logic [39:0]              lo_q;
  logic [38:0]              hi_q;
  logic signed [SpeedW-1:0] corr_q, lcmd_q, rcmd_q;

  logic signed [SpeedW-1:0] res_l_q, res_r_q, res_c_q;
  logic signed [ErrW-1:0]   res_e_q;
  logic                     res_a_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q  <= '0;
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      max_corr_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMinSpeed: min_speed_q  <= cfg_data_i[14:0];
        RegPropGain: prop_gain_q  <= cfg_data_i;
        RegIntGain:  integ_gain_q <= cfg_data_i;
        RegMaxCorr:  max_corr_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? 16'(-v) : 16'(v);
  endfunction

  // gating check
  logic [15:0] lmag, rmag, slow, peak;
  logic        act_ok;
  assign lmag   = abs16(lt_q);
  assign rmag   = abs16(rt_q);
  assign slow   = (lmag < rmag) ? lmag : rmag;
  assign peak   = (lmag > rmag) ? lmag : rmag;
  assign act_ok = fresh_q && (lt_q != 0) && (rt_q != 0) && (lt_q[15] == rt_q[15])
                  && (slow >= {1'b0, min_speed_q}) && (dt_q != 0);

  // divider operands
  logic signed [15:0] dnum, dden;
  logic [15:0]        anum, aden;
  assign dnum = cmd_i.div_sel ? ra_q : la_q;
  assign dden = cmd_i.div_sel ? rt_q : lt_q;
  assign anum = abs16(dnum);
  assign aden = abs16(dden);

  logic signed [15:0] ratio;
  always_comb begin
    if (ovf_q) begin
      ratio = neg_q ? 16'sh8000 : 16'sh7fff;
    end else begin
      ratio = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    end
  end

  // integral update
  logic signed [33:0] pdt_adj;
  logic signed [29:0] inc, acc_sum, acc_new;
  assign pdt_adj = pdt_q + (pdt_q[33] ? 34'sd15 : 34'sd0);
  assign inc     = 30'(pdt_adj >>> 4);
  assign acc_sum = inc + 30'(acc_q);
  always_comb begin
    if (acc_sum > IntegLimit)       acc_new = IntegLimit;
    else if (acc_sum < -IntegLimit) acc_new = -IntegLimit;
    else                            acc_new = acc_sum;
  end

  // pi sum
  logic signed [47:0] sum;
  assign sum = (48'(pterm_q) <<< 12) + 48'(iterm_q);

  // correction clamp
  logic [63:0] total;
  logic [31:0] raw;
  logic [14:0] cmag;
  assign total = {1'b0, hi_q, 24'b0} + {24'b0, lo_q};
  assign raw   = total[63:32];
  assign cmag  = (raw > {17'b0, max_corr_q}) ? max_corr_q : raw[14:0];

  // command shaping
  logic signed [17:0] lsum, rsum;
  logic signed [15:0] lk, rk;
  assign lsum = lt_q[15] ? 18'(lt_q) - 18'(corr_q) : 18'(lt_q) + 18'(corr_q);
  assign rsum = lt_q[15] ? 18'(rt_q) + 18'(corr_q) : 18'(rt_q) - 18'(corr_q);

  function automatic logic signed [15:0] keep(input logic signed [17:0] v,
                                              input logic signed [15:0] ref_v);
    logic signed [17:0] h;
    begin
      if (!ref_v[15]) h = v[17] ? 18'sd0 : v;
      else            h = (v > 0) ? 18'sd0 : v;
      if (h > 18'sd32767)       keep = 16'sh7fff;
      else if (h < -18'sd32768) keep = 16'sh8000;
      else                      keep = h[15:0];
    end
  endfunction

  assign lk = keep(lsum, lt_q);
  assign rk = keep(rsum, rt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      lt_q    <= in_data_i[15:0];
      rt_q    <= in_data_i[31:16];
      la_q    <= in_data_i[47:32];
      ra_q    <= in_data_i[63:48];
      dt_q    <= in_data_i[79:64];
      fresh_q <= in_fresh_i;
    end
    if (cmd_i.check) begin
      act_q  <= act_ok;
      peak_q <= peak;
    end
    if (cmd_i.div_load) begin
      rem_q <= {anum, 12'b0};
      dsh_q <= {aden, 14'b0};
      quo_q <= '0;
      ovf_q <= {3'b0, anum} >= {aden, 3'b0};
      neg_q <= dnum[15] ^ dden[15];
    end else if (cmd_i.div_step) begin
      if ({2'b0, rem_q} >= dsh_q) begin
        rem_q <= rem_q - dsh_q[27:0];
        quo_q <= {quo_q[QuotW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QuotW-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.store_l) lratio_q <= ratio;
    if (cmd_i.store_r) rratio_q <= ratio;
    if (cmd_i.m1) begin
      err_q <= 17'(rratio_q) - 17'(lratio_q);
    end
    if (cmd_i.m2) begin
      pdt_q   <= err_q * $signed({1'b0, dt_q});
      pterm_q <= err_q * $signed({1'b0, prop_gain_q});
    end
    if (cmd_i.m4) begin
      iterm_q <= acc_q * $signed({1'b0, integ_gain_q});
    end
    if (cmd_i.m5) begin
      smag_q <= sum[47] ? 47'(-sum) : sum[46:0];
      sneg_q <= sum[47];
    end
    if (cmd_i.m6) begin
      lo_q <= smag_q[23:0] * peak_q;
      hi_q <= smag_q[46:24] * peak_q;
    end
    if (cmd_i.m7) begin
      corr_q <= sneg_q ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    end
    if (cmd_i.out_load) begin
      res_a_q <= act_q;
      if (act_q) begin
        res_l_q <= lk;
        res_r_q <= rk;
        res_e_q <= err_q;
        res_c_q <= corr_q;
      end else begin
        res_l_q <= lt_q;
        res_r_q <= rt_q;
        res_e_q <= '0;
        res_c_q <= '0;
      end
    end
  end

  // divider step count and integral state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      acc_q <= '0;
    end else begin
      if (cmd_i.div_load)                    cnt_q <= DivCntW'(QuotW);
      else if (cmd_i.div_step && cnt_q != 0) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.clr_acc)  acc_q <= '0;
      else if (cmd_i.m3)  acc_q <= acc_new[AccW-1:0];
    end
  end

  assign status_o.act_ok   = act_ok;
  assign status_o.div_busy = (cnt_q != 0);

  assign out_data_o   = {7'b0, res_c_q, res_e_q, res_r_q, res_l_q};
  assign out_active_o = res_a_q;

endmodule
